[sv/lrc_tp_pkg.sv]
// ============================================================================
// LRC time tag parser package
// Character codes, phase codes and output widths shared by the parser blocks.
// ============================================================================
`default_nettype none

package lrc_tp_pkg;

    // Default digit limit for each number of a tag.
    localparam int MAX_DIGITS_DEF = 3;

    // Characters that the tag grammar knows.
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // Parser phases.
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_OPEN  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_MIN   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_COLON = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SEC   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DOT   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_FRAC  = 3'd6;

    // Result fields.
    localparam int TIME_W  = 26;
    localparam int COUNT_W = 16;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam int MS_PER_MIN  = 60000;
    localparam int MS_PER_SEC  = 1000;
    localparam int MS_PER_FRAC = 10;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

endpackage

`default_nettype wire

[sv/lrc_tp_parser.sv]
// ============================================================================
// LRC time tag parser: tag recogniser
// Walks the tag grammar one byte per beat, gathers the three numbers and
// holds each completed tag in a one-entry register for the time stage.
// ============================================================================
`default_nettype none

module lrc_tp_parser #(
    parameter int MAX_DIGITS = lrc_tp_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  accept_short_form,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [7:0]                            data_byte,
    input  wire logic                                  restart,
    output logic                                       emit_valid,
    input  wire logic                                  emit_ready,
    output logic [$clog2(10**MAX_DIGITS)-1:0]          emit_min,
    output logic [$clog2(10**MAX_DIGITS)-1:0]          emit_sec,
    output logic [$clog2(10**MAX_DIGITS)-1:0]          emit_frac,
    output logic                                       emit_has_frac,
    output logic                                       emit_sat,
    output logic [lrc_tp_pkg::COUNT_W-1:0]             emit_count
);
    import lrc_tp_pkg::*;

    localparam int ACC_W = $clog2(10**MAX_DIGITS);
    localparam int RUN_W = $clog2(MAX_DIGITS + 1);
    localparam logic [ACC_W-1:0] NUM_LIMIT = ACC_W'(10**MAX_DIGITS - 1);
    localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(MAX_DIGITS);

    logic [PHASE_W-1:0] phase_reg, phase_next, phase_cur;
    logic [ACC_W-1:0]   min_reg, min_next, min_cur;
    logic [ACC_W-1:0]   sec_reg, sec_next, sec_cur;
    logic [ACC_W-1:0]   frac_reg, frac_next, frac_cur;
    logic [RUN_W-1:0]   run_reg, run_next, run_cur;
    logic               sat_reg, sat_next, sat_cur;
    logic [COUNT_W-1:0] tags_reg, tags_next, tags_cur;

    logic               emit_valid_reg, emit_valid_next;
    logic [ACC_W-1:0]   emit_min_reg, emit_sec_reg, emit_frac_reg;
    logic               emit_has_frac_reg, emit_sat_reg;
    logic [COUNT_W-1:0] emit_count_reg;

    logic               accept;
    logic               is_digit;
    logic [3:0]         digit;
    logic               run_full;
    logic               fire;
    logic               fire_frac;

    function automatic logic [ACC_W-1:0] grow(input logic [ACC_W-1:0] acc,
                                              input logic [3:0] d);
        logic [ACC_W+3:0] w;
        w = (ACC_W+4)'(acc) * (ACC_W+4)'(10) + (ACC_W+4)'(d);
        return w[ACC_W-1:0];
    endfunction

    assign in_ready = !emit_valid_reg || emit_ready;
    assign accept   = in_valid && in_ready;
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign digit    = data_byte[3:0];

    always_comb begin
        // A restart beat sees a freshly cleared parser.
        phase_cur = restart ? PH_IDLE : phase_reg;
        min_cur   = restart ? '0 : min_reg;
        sec_cur   = restart ? '0 : sec_reg;
        frac_cur  = restart ? '0 : frac_reg;
        run_cur   = restart ? '0 : run_reg;
        sat_cur   = restart ? 1'b0 : sat_reg;
        tags_cur  = restart ? '0 : tags_reg;
        run_full  = run_cur >= RUN_LIMIT;

        phase_next = phase_cur;
        min_next   = min_cur;
        sec_next   = sec_cur;
        frac_next  = frac_cur;
        run_next   = run_cur;
        sat_next   = sat_cur;
        fire       = 1'b0;
        fire_frac  = 1'b0;

        case (phase_cur)
            PH_OPEN: begin
                if (is_digit) begin
                    min_next   = ACC_W'(digit);
                    run_next   = RUN_W'(1);
                    phase_next = PH_MIN;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_MIN: begin
                if (is_digit) begin
                    if (run_full) begin
                        min_next = NUM_LIMIT;
                        sat_next = 1'b1;
                    end else begin
                        min_next = grow(min_cur, digit);
                        run_next = run_cur + RUN_W'(1);
                    end
                end else if (data_byte == CH_COLON) begin
                    phase_next = PH_COLON;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_COLON: begin
                if (is_digit) begin
                    sec_next   = ACC_W'(digit);
                    run_next   = RUN_W'(1);
                    phase_next = PH_SEC;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_SEC: begin
                if (is_digit) begin
                    if (run_full) begin
                        sec_next = NUM_LIMIT;
                        sat_next = 1'b1;
                    end else begin
                        sec_next = grow(sec_cur, digit);
                        run_next = run_cur + RUN_W'(1);
                    end
                end else if (data_byte == CH_DOT) begin
                    phase_next = PH_DOT;
                end else begin
                    fire       = (data_byte == CH_CLOSE) && accept_short_form;
                    phase_next = PH_IDLE;
                end
            end
            PH_DOT: begin
                if (is_digit) begin
                    frac_next  = ACC_W'(digit);
                    run_next   = RUN_W'(1);
                    phase_next = PH_FRAC;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_FRAC: begin
                if (is_digit) begin
                    if (run_full) begin
                        frac_next = NUM_LIMIT;
                        sat_next  = 1'b1;
                    end else begin
                        frac_next = grow(frac_cur, digit);
                        run_next  = run_cur + RUN_W'(1);
                    end
                end else begin
                    fire       = (data_byte == CH_CLOSE);
                    fire_frac  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // A '[' opens a new tag from any phase, expected or not.
        if (data_byte == CH_OPEN) begin
            phase_next = PH_OPEN;
            min_next   = '0;
            sec_next   = '0;
            frac_next  = '0;
            run_next   = '0;
            sat_next   = 1'b0;
        end

        tags_next = fire ? tags_cur + COUNT_W'(1) : tags_cur;

        if (accept && fire) begin
            emit_valid_next = 1'b1;
        end else if (emit_ready) begin
            emit_valid_next = 1'b0;
        end else begin
            emit_valid_next = emit_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            min_reg        <= '0;
            sec_reg        <= '0;
            frac_reg       <= '0;
            run_reg        <= '0;
            sat_reg        <= 1'b0;
            tags_reg       <= '0;
            emit_valid_reg <= 1'b0;
        end else begin
            emit_valid_reg <= emit_valid_next;
            if (accept) begin
                phase_reg <= phase_next;
                min_reg   <= min_next;
                sec_reg   <= sec_next;
                frac_reg  <= frac_next;
                run_reg   <= run_next;
                sat_reg   <= sat_next;
                tags_reg  <= tags_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && fire) begin
            emit_min_reg      <= min_cur;
            emit_sec_reg      <= sec_cur;
            emit_frac_reg     <= frac_cur;
            emit_has_frac_reg <= fire_frac;
            emit_sat_reg      <= sat_cur;
            emit_count_reg    <= tags_next;
        end
    end

    assign emit_valid    = emit_valid_reg;
    assign emit_min      = emit_min_reg;
    assign emit_sec      = emit_sec_reg;
    assign emit_frac     = emit_frac_reg;
    assign emit_has_frac = emit_has_frac_reg;
    assign emit_sat      = emit_sat_reg;
    assign emit_count    = emit_count_reg;

    a_restart_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && restart && (data_byte != CH_OPEN) |=> phase_reg == PH_IDLE)
        else $error("restart beat did not leave the parser idle");

    a_open_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (data_byte == CH_OPEN) |=> (phase_reg == PH_OPEN) && (run_reg == '0))
        else $error("'[' did not open a fresh tag");

    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= RUN_LIMIT)
        else $error("digit run exceeded the digit limit");

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && fire && !restart |=> tags_reg == $past(tags_reg) + COUNT_W'(1))
        else $error("tag count did not advance by one on a tag");

endmodule

`default_nettype wire

[sv/lrc_tp_timecalc.sv]
// ============================================================================
// LRC time tag parser: time stage
// Turns minutes, seconds and hundredths into milliseconds with saturation
// and holds the result beat until the receiver takes it.
// ============================================================================
`default_nettype none

module lrc_tp_timecalc #(
    parameter int MAX_DIGITS = lrc_tp_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [$clog2(10**MAX_DIGITS)-1:0]     in_min,
    input  wire logic [$clog2(10**MAX_DIGITS)-1:0]     in_sec,
    input  wire logic [$clog2(10**MAX_DIGITS)-1:0]     in_frac,
    input  wire logic                                  in_has_frac,
    input  wire logic                                  in_sat,
    input  wire logic [lrc_tp_pkg::COUNT_W-1:0]        in_count,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [lrc_tp_pkg::TIME_W-1:0]              out_time_ms,
    output logic                                       out_has_fraction,
    output logic                                       out_overflow,
    output logic [lrc_tp_pkg::COUNT_W-1:0]             out_tag_count
);
    import lrc_tp_pkg::*;

    localparam int ACC_W = $clog2(10**MAX_DIGITS);
    localparam int SUM_W = (ACC_W + 17 > TIME_W + 1) ? ACC_W + 17 : TIME_W + 1;

    logic               valid_reg, valid_next;
    logic [TIME_W-1:0]  time_reg;
    logic               has_frac_reg, overflow_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [SUM_W-1:0]   min_ms, sec_ms, frac_ms, sum_ms;
    logic [TIME_W-1:0]  time_sat;
    logic               load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        min_ms   = SUM_W'(in_min) * SUM_W'(MS_PER_MIN);
        sec_ms   = SUM_W'(in_sec) * SUM_W'(MS_PER_SEC);
        frac_ms  = in_has_frac ? SUM_W'(in_frac) * SUM_W'(MS_PER_FRAC) : '0;
        sum_ms   = min_ms + sec_ms + frac_ms;
        time_sat = (sum_ms > SUM_W'(TIME_MAX)) ? TIME_MAX : sum_ms[TIME_W-1:0];

        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            time_reg     <= time_sat;
            has_frac_reg <= in_has_frac;
            overflow_reg <= in_sat;
            count_reg    <= in_count;
        end
    end

    assign out_valid        = valid_reg;
    assign out_time_ms      = time_reg;
    assign out_has_fraction = has_frac_reg;
    assign out_overflow     = overflow_reg;
    assign out_tag_count    = count_reg;

endmodule

`default_nettype wire

[sv/lrc_time_tag_parser_unit.sv]
// ============================================================================
// LRC time tag parser
// Recognises [min:sec] and [min:sec.frac] tags in a lyric byte stream.
// ============================================================================
// The slave stream carries one text byte per beat in s_axis_tdata, with
// s_axis_tuser set on the first byte of a new file to clear the parser and
// the tag count. The master stream gives one beat per completed tag: the
// time in milliseconds and the running tag count in m_axis_tdata, the
// fraction and overflow flags in m_axis_tuser.
// A byte is taken every cycle while s_axis_tready is high. The closing
// ']' of a tag passes the recogniser's tag register and then the
// millisecond stage's output register before its result beat appears.
// When the receiver stalls, the output register and the tag register hold
// one result each. Bytes keep flowing while the tag register is empty; once
// both registers are full, s_axis_tready stays low until the receiver takes
// a beat, whatever the next byte is.
// cfg_we writes accept_short_form; with it low, tags without a fraction are
// dropped and not counted. Reset leaves the parser idle, the count at zero
// and accept_short_form set.
// ============================================================================
`default_nettype none

module lrc_time_tag_parser_unit #(
    parameter int MAX_DIGITS = lrc_tp_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_wdata,      // accept_short_form
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [lrc_tp_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // data_byte
    input  wire logic                               s_axis_tuser,   // restart
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [lrc_tp_pkg::M_TDATA_W-1:0]        m_axis_tdata,   // time_ms, tag_count, pad
    output logic [lrc_tp_pkg::M_TUSER_W-1:0]        m_axis_tuser    // has_fraction, overflow
);
    import lrc_tp_pkg::*;

    localparam int ACC_W = $clog2(10**MAX_DIGITS);
    localparam int PAD_W = M_TDATA_W - TIME_W - COUNT_W;

    logic               short_form_reg;

    logic               emit_valid, emit_ready;
    logic [ACC_W-1:0]   emit_min, emit_sec, emit_frac;
    logic               emit_has_frac, emit_sat;
    logic [COUNT_W-1:0] emit_count;

    logic [TIME_W-1:0]  time_ms;
    logic               has_fraction, overflow;
    logic [COUNT_W-1:0] tag_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_form_reg <= 1'b1;
        end else if (cfg_we) begin
            short_form_reg <= cfg_wdata;
        end
    end

    lrc_tp_parser #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_parser (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .accept_short_form (short_form_reg),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .data_byte         (s_axis_tdata),
        .restart           (s_axis_tuser),
        .emit_valid        (emit_valid),
        .emit_ready        (emit_ready),
        .emit_min          (emit_min),
        .emit_sec          (emit_sec),
        .emit_frac         (emit_frac),
        .emit_has_frac     (emit_has_frac),
        .emit_sat          (emit_sat),
        .emit_count        (emit_count)
    );

    lrc_tp_timecalc #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_timecalc (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (emit_valid),
        .in_ready         (emit_ready),
        .in_min           (emit_min),
        .in_sec           (emit_sec),
        .in_frac          (emit_frac),
        .in_has_frac      (emit_has_frac),
        .in_sat           (emit_sat),
        .in_count         (emit_count),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_time_ms      (time_ms),
        .out_has_fraction (has_fraction),
        .out_overflow     (overflow),
        .out_tag_count    (tag_count)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, tag_count, time_ms};
    assign m_axis_tuser = {overflow, has_fraction};

endmodule

`default_nettype wire
